[src/wteq_pkg.sv]
`timescale 1ns / 1ps
package wteq_pkg;
  localparam int TIME_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF = 8;

  localparam logic MODE_REG = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam logic KIND_FIRED = 1'b0;
  localparam logic KIND_COUNT = 1'b1;
endpackage

[src/wteq_ram.sv]
`timescale 1ns / 1ps
module wteq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/wrapping_timer_expiry_queue.sv]
`timescale 1ns / 1ps
// register word: ST_REG writes the entry, then the current queue is scanned entry by entry
// via ST_RD and ST_CMP, and ST_DEC gives the countdown word (ST_LOOP if the queue is empty)
// tick: each report follows a fresh scan of the current queue after the word or the previous
// report is taken; at the epoch swap the old queue is drained, then ST_LOOP switches queues
// throughput: one word in flight at a time, in_ready again the cycle after the last report
// reset: rst_n synchronous active low clears state, counts, epoch select, last tick time and flags
module wrapping_timer_expiry_queue #(
  parameter int TIME_BITS = wteq_pkg::TIME_BITS_DEF,
  parameter int QUEUE_DEPTH = wteq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS = wteq_pkg::ID_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [TIME_BITS-1:0] in_now,
  input  logic [TIME_BITS-1:0] in_wait_req,
  input  logic [ID_BITS-1:0]   in_timer_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [ID_BITS-1:0]   out_fired_id,
  output logic [TIME_BITS:0]   out_countdown,
  output logic                 out_queue_full,
  output logic                 out_last
);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TIME_BITS + ID_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REG = 3'd1;
  localparam logic [2:0] ST_LOOP = 3'd2;
  localparam logic [2:0] ST_RD = 3'd3;
  localparam logic [2:0] ST_CMP = 3'd4;
  localparam logic [2:0] ST_DEC = 3'd5;
  localparam logic [2:0] ST_OUT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic cur_r, cur_nxt;
  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;
  logic tick_r, tick_nxt, drain_r, drain_nxt, done_r, done_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt, wait_r, wait_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [EW-1:0] best_r, best_nxt, tail_r, tail_nxt;
  logic full_r, full_nxt;

  logic ov_r, ov_nxt, kind_r, kind_nxt, oful_r, oful_nxt, olast_r, olast_nxt;
  logic [ID_BITS-1:0] oid_r, oid_nxt;
  logic [TIME_BITS:0] ocd_r, ocd_nxt;

  logic we_a, we_b;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rd_a, rd_b, rd;
  logic [CW-1:0] cur_cnt;
  logic [TIME_BITS:0] dl_sum;
  logic tgt;
  logic [CW-1:0] tgt_cnt;

  assign cur_cnt = cur_r ? cnt_b_r : cnt_a_r;
  assign rd = cur_r ? rd_b : rd_a;
  assign raddr = idx_r[IW-1:0];
  assign dl_sum = {1'b0, now_r} + {1'b0, wait_r};
  assign tgt = cur_r ^ dl_sum[TIME_BITS];
  assign tgt_cnt = tgt ? cnt_b_r : cnt_a_r;

  wteq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_a)
  );
  wteq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_b)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    cur_nxt = cur_r;
    last_time_nxt = last_time_r;
    tick_nxt = tick_r;
    drain_nxt = drain_r;
    done_nxt = done_r;
    now_nxt = now_r;
    wait_nxt = wait_r;
    id_nxt = id_r;
    idx_nxt = idx_r;
    best_idx_nxt = best_idx_r;
    best_nxt = best_r;
    tail_nxt = tail_r;
    full_nxt = full_r;
    ov_nxt = ov_r;
    kind_nxt = kind_r;
    oid_nxt = oid_r;
    ocd_nxt = ocd_r;
    oful_nxt = oful_r;
    olast_nxt = olast_r;
    we_a = 1'b0;
    we_b = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt = in_now;
          wait_nxt = in_wait_req;
          id_nxt = in_timer_id;
          tick_nxt = (in_mode == wteq_pkg::MODE_TICK);
          drain_nxt = (in_mode == wteq_pkg::MODE_TICK) && (in_now < last_time_r);
          full_nxt = 1'b0;
          state_nxt = (in_mode == wteq_pkg::MODE_TICK) ? ST_LOOP : ST_REG;
        end
      end
      ST_REG: begin
        waddr = tgt_cnt[IW-1:0];
        wdata = {dl_sum[TIME_BITS-1:0], id_r};
        if (tgt_cnt == FULL_CNT) begin
          full_nxt = 1'b1;
        end else if (tgt) begin
          we_b = 1'b1;
          cnt_b_nxt = cnt_b_r + 1'b1;
        end else begin
          we_a = 1'b1;
          cnt_a_nxt = cnt_a_r + 1'b1;
        end
        state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (cur_cnt == '0) begin
          if (drain_r) begin
            cur_nxt = ~cur_r;
            drain_nxt = 1'b0;
          end else begin
            ov_nxt = 1'b1;
            kind_nxt = wteq_pkg::KIND_COUNT;
            oid_nxt = '0;
            ocd_nxt = {1'b1, {TIME_BITS{1'b0}}} - {1'b0, now_r};
            oful_nxt = full_r;
            olast_nxt = 1'b1;
            done_nxt = 1'b1;
            if (tick_r) begin
              last_time_nxt = now_r;
            end
            state_nxt = ST_OUT;
          end
        end else begin
          idx_nxt = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        tail_nxt = rd;
        if (idx_r == '0 || rd[EW-1:ID_BITS] < best_r[EW-1:ID_BITS] ||
            (rd[EW-1:ID_BITS] == best_r[EW-1:ID_BITS] &&
             rd[ID_BITS-1:0] < best_r[ID_BITS-1:0])) begin
          best_nxt = rd;
          best_idx_nxt = idx_r[IW-1:0];
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = (idx_r + 1'b1 < cur_cnt) ? ST_RD : ST_DEC;
      end
      ST_DEC: begin
        ov_nxt = 1'b1;
        oful_nxt = 1'b0;
        if (drain_r || (tick_r && best_r[EW-1:ID_BITS] <= now_r)) begin
          waddr = best_idx_r;
          wdata = tail_r;
          if (cur_r) begin
            we_b = 1'b1;
            cnt_b_nxt = cnt_b_r - 1'b1;
          end else begin
            we_a = 1'b1;
            cnt_a_nxt = cnt_a_r - 1'b1;
          end
          kind_nxt = wteq_pkg::KIND_FIRED;
          oid_nxt = best_r[ID_BITS-1:0];
          ocd_nxt = '0;
          olast_nxt = 1'b0;
          done_nxt = 1'b0;
        end else begin
          kind_nxt = wteq_pkg::KIND_COUNT;
          oid_nxt = '0;
          ocd_nxt = {1'b0, best_r[EW-1:ID_BITS] - now_r};
          oful_nxt = full_r;
          olast_nxt = 1'b1;
          done_nxt = 1'b1;
          if (tick_r) begin
            last_time_nxt = now_r;
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          ov_nxt = 1'b0;
          state_nxt = done_r ? ST_IDLE : ST_LOOP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      cur_r <= 1'b0;
      last_time_r <= '0;
      ov_r <= 1'b0;
      tick_r <= 1'b0;
      drain_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_a_r <= cnt_a_nxt;
      cnt_b_r <= cnt_b_nxt;
      cur_r <= cur_nxt;
      last_time_r <= last_time_nxt;
      ov_r <= ov_nxt;
      tick_r <= tick_nxt;
      drain_r <= drain_nxt;
      done_r <= done_nxt;
    end
    now_r <= now_nxt;
    wait_r <= wait_nxt;
    id_r <= id_nxt;
    idx_r <= idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r <= best_nxt;
    tail_r <= tail_nxt;
    full_r <= full_nxt;
    kind_r <= kind_nxt;
    oid_r <= oid_nxt;
    ocd_r <= ocd_nxt;
    oful_r <= oful_nxt;
    olast_r <= olast_nxt;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_fired_id = oid_r;
  assign out_countdown = ocd_r;
  assign out_queue_full = oful_r;
  assign out_last = olast_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= FULL_CNT) && (cnt_b_r <= FULL_CNT))
    else $error("queue count beyond depth");
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == wteq_pkg::KIND_FIRED) |-> !out_last)
    else $error("fired word marked last");
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not idle after final word");
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("output pending while idle");
endmodule

[sim/timer_queue_checker.sv]
`timescale 1ns / 1ps
module timer_queue_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_now,
  input  logic [31:0] in_wait_req,
  input  logic [7:0]  in_timer_id,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic [7:0]  out_fired_id,
  input  logic [32:0] out_countdown,
  input  logic        out_queue_full,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_reports
);
  localparam int DEPTH = 16;

  typedef struct packed {
    logic        kind;
    logic [7:0]  fired_id;
    logic [32:0] countdown;
    logic        queue_full;
    logic        last;
  } report_t;

  logic [31:0] dl_q [2][DEPTH];
  logic [7:0]  id_q [2][DEPTH];
  int          fill [2];
  logic        cur_b;
  logic [31:0] prev_tick;
  report_t     expected_reports [$];

  assign pending_reports = expected_reports.size();

  function automatic int earliest(input logic s);
    int best;
    best = 0;
    for (int i = 1; i < fill[s]; i++)
      if (dl_q[s][i] < dl_q[s][best] ||
          (dl_q[s][i] == dl_q[s][best] && id_q[s][i] < id_q[s][best]))
        best = i;
    return best;
  endfunction

  function automatic logic [32:0] next_wake(input logic [31:0] t);
    logic [31:0] diff;
    if (fill[cur_b] > 0) begin
      diff = dl_q[cur_b][earliest(cur_b)] - t;
      return {1'b0, diff};
    end
    return 33'h1_0000_0000 - {1'b0, t};
  endfunction

  task automatic fire_due(input logic [31:0] t, input bit all);
    int m;
    report_t r;
    while (fill[cur_b] > 0) begin
      m = earliest(cur_b);
      if (!all && dl_q[cur_b][m] > t) break;
      r = '{wteq_pkg::KIND_FIRED, id_q[cur_b][m], 33'd0, 1'b0, 1'b0};
      expected_reports.push_back(r);
      dl_q[cur_b][m] = dl_q[cur_b][fill[cur_b]-1];
      id_q[cur_b][m] = id_q[cur_b][fill[cur_b]-1];
      fill[cur_b]--;
    end
  endtask

  task automatic predict_word(input logic md, input logic [31:0] t, input logic [31:0] w,
                              input logic [7:0] id);
    logic [31:0] dl;
    logic tgt;
    logic full;
    report_t r;
    if (md == wteq_pkg::MODE_REG) begin
      dl = t + w;
      tgt = (dl < t) ? !cur_b : cur_b;
      full = 1'b0;
      if (fill[tgt] < DEPTH) begin
        dl_q[tgt][fill[tgt]] = dl;
        id_q[tgt][fill[tgt]] = id;
        fill[tgt]++;
      end else full = 1'b1;
      r = '{wteq_pkg::KIND_COUNT, 8'd0, next_wake(t), full, 1'b1};
      expected_reports.push_back(r);
    end else begin
      if (t < prev_tick) begin
        fire_due(t, 1);
        fill[cur_b] = 0;
        cur_b = !cur_b;
      end
      fire_due(t, 0);
      r = '{wteq_pkg::KIND_COUNT, 8'd0, next_wake(t), 1'b0, 1'b1};
      expected_reports.push_back(r);
      prev_tick = t;
    end
  endtask

  always @(posedge clk) begin
    report_t exp_r, got;
    if (!rst_n) begin
      fill[0] = 0;
      fill[1] = 0;
      cur_b = 1'b0;
      prev_tick = '0;
      fail_count = 0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_kind, out_fired_id, out_countdown, out_queue_full, out_last};
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected word kind=%0d id=%0d cd=%0d full=%0d last=%0d",
                   $time, got.kind, got.fired_id, got.countdown, got.queue_full, got.last);
          fail_count++;
        end else begin
          exp_r = expected_reports.pop_front();
          if (got != exp_r) begin
            $display("%0t: mismatch expected kind=%0d id=%0d cd=%0d full=%0d last=%0d",
                     $time, exp_r.kind, exp_r.fired_id, exp_r.countdown, exp_r.queue_full,
                     exp_r.last);
            $display("%0t:          actual   kind=%0d id=%0d cd=%0d full=%0d last=%0d",
                     $time, got.kind, got.fired_id, got.countdown, got.queue_full, got.last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_word(in_mode, in_now, in_wait_req, in_timer_id);
    end
  end
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [31:0] in_now;
  logic [31:0] in_wait_req;
  logic [7:0]  in_timer_id;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [7:0]  out_fired_id;
  logic [32:0] out_countdown;
  logic        out_queue_full;
  logic        out_last;
  int          fail_count;
  int          pending_reports;
  logic [31:0] clock_now;
  bit          stall_enable;

  wrapping_timer_expiry_queue dut (.*);

  timer_queue_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL wrapping_timer_expiry_queue");
    $finish;
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      gap = stall_enable ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_word(input logic md, input logic [31:0] t, input logic [31:0] w,
                           input logic [7:0] id);
    int gap;
    gap = stall_enable ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_now <= t;
    in_wait_req <= w;
    in_timer_id <= id;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_epoch(input int n);
    int sel;
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: w = $urandom();
        1: w = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: w = $urandom_range(0, 400);
      endcase
      if (sel < 6) begin
        send_word(wteq_pkg::MODE_REG, clock_now, w, $urandom());
      end else begin
        if ($urandom_range(0, 14) == 0) clock_now = $urandom_range(0, 300);
        else if ($urandom_range(0, 14) == 0) clock_now = $urandom();
        else clock_now = clock_now + $urandom_range(0, 120);
        send_word(wteq_pkg::MODE_TICK, clock_now, $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = wteq_pkg::MODE_REG;
    in_now = '0;
    in_wait_req = '0;
    in_timer_id = '0;
    stall_enable = 1'b0;
    clock_now = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, equal deadlines, wrap into overflow queue, full queue
    send_word(wteq_pkg::MODE_TICK, 32'd0, 32'd0, 8'd0);
    send_word(wteq_pkg::MODE_REG, 32'd0, 32'd0, 8'hFF);
    send_word(wteq_pkg::MODE_REG, 32'd10, 32'd5, 8'd7);
    send_word(wteq_pkg::MODE_REG, 32'd10, 32'd5, 8'd3);
    send_word(wteq_pkg::MODE_REG, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 8'hAA);
    send_word(wteq_pkg::MODE_TICK, 32'd15, 32'hFFFF_FFFF, 8'hFF);
    for (int i = 0; i < 17; i++)
      send_word(wteq_pkg::MODE_REG, 32'd20, 32'd100 + i, i[7:0]);
    send_word(wteq_pkg::MODE_TICK, 32'hFFFF_FFFF, 32'd0, 8'd0);
    send_word(wteq_pkg::MODE_TICK, 32'd5, 32'd0, 8'd0);
    send_word(wteq_pkg::MODE_TICK, 32'd0, 32'd0, 8'd0);
    drain_reports();

    stall_enable = 1'b1;
    clock_now = 32'd1000;
    for (int p = 0; p < 6; p++) begin
      stall_enable = (p != 2);
      random_epoch(38);
      drain_reports();
    end

    if (fail_count == 0)
      $display("PASS wrapping_timer_expiry_queue");
    else
      $display("FAIL wrapping_timer_expiry_queue");
    $finish;
  end
endmodule
